// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// Depends on nothing; include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk while rstn is high.
`define RROF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Check that expr never holds at a rising edge of clk while rstn is high.
`define RROF_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ===== design/rrof_pkg.sv =====
// Types and constants for the read region overlap filter.
// Holds CIGAR codes, register indexes and stream payload layouts; no dependencies.
package rrof_pkg;

  localparam int unsigned POS_W    = 31;
  localparam int unsigned FLAGS_W  = 12;
  localparam int unsigned OP_W     = 4;
  localparam int unsigned LEN_W    = 28;
  localparam int unsigned CURSOR_W = 33;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [OP_W-1:0] OP_MATCH    = 4'd0;
  localparam logic [OP_W-1:0] OP_DELETION = 4'd2;
  localparam logic [OP_W-1:0] OP_SKIP     = 4'd3;
  localparam logic [OP_W-1:0] OP_PADDING  = 4'd6;
  localparam logic [OP_W-1:0] OP_EQUAL    = 4'd7;
  localparam logic [OP_W-1:0] OP_MISMATCH = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROPER_PAIR  = 2'd2;

  localparam int unsigned FLAG_PAIRED    = 0;
  localparam int unsigned FLAG_PROPER    = 1;
  localparam int unsigned FLAG_SECONDARY = 8;

  typedef struct packed {
    logic [4:0]         fill;
    logic [LEN_W-1:0]   cigar_len;
    logic [OP_W-1:0]    cigar_op;
    logic [FLAGS_W-1:0] read_flags;
    logic [POS_W-1:0]   read_pos;
  } in_data_t;

  typedef struct packed {
    logic [4:0]         fill;
    logic [COUNT_W-1:0] hit_count;
    logic               padding_error;
    logic               read_filtered;
    logic               read_hit;
  } out_data_t;

  typedef struct packed {
    logic aligned;
    logic advances;
    logic padding;
  } op_class_t;

endpackage

// ===== design/read_region_overlap_filter_unit.sv =====
// Read region overlap filter: one CIGAR operation per request, one result per read.
// Depends on rrof_pkg and assert_macros.svh.
//
// The block takes one CIGAR operation per clock while no stalled result holds it
// back; a result leaves after the last operation of its read is accepted, through
// the input register, then the result register. The rate is set by the
// reference cursor loop: each operation's add and region compares must update
// the cursor before the next operation uses it. A stalled result holds back
// the operation that ends a read, and with it all input. The user must write
// region registers only while no read is in flight; the block does not enforce it.
module read_region_overlap_filter_unit
  import rrof_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // read_pos, read_flags, cigar_op, cigar_len, zeros
  input  logic                  in_tuser,   // first_op
  input  logic                  in_tlast,   // last_op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // read_hit, read_filtered, padding_error,
                                            // hit_count, zeros
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [POS_W-1:0]      cfg_data
);

  logic                s1_valid_r;
  in_data_t            s1_data_r;
  logic                s1_first_r;
  logic                s1_last_r;
  logic                s1_adv;

  logic [POS_W-1:0]    region_start_r;
  logic [POS_W-1:0]    region_end_r;
  logic                req_pair_r;

  logic [CURSOR_W-1:0] cursor_r, cursor_nxt;
  logic                hit_seen_r, hit_seen_nxt;
  logic                dropped_r, dropped_nxt;
  logic                pad_seen_r, pad_seen_nxt;
  logic [COUNT_W-1:0]  hits_total_r, hits_total_nxt;

  logic                out_valid_r;
  out_data_t           out_data_r, out_data_nxt;
  logic                out_free;

  logic [CURSOR_W-1:0] cur;
  logic                hit0, pad0;
  logic [CURSOR_W:0]   sum;
  logic                overlap;
  logic                walk;
  logic                hit_out;
  op_class_t           cls;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign s1_adv     = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    cls = '0;
    case (s1_data_r.cigar_op) inside
      OP_MATCH, OP_EQUAL, OP_MISMATCH: begin
        cls.aligned  = 1'b1;
        cls.advances = 1'b1;
      end
      OP_DELETION, OP_SKIP: begin
        cls.advances = 1'b1;
      end
      OP_PADDING: begin
        cls.padding = 1'b1;
      end
      default: begin
        cls = '0;
      end
    endcase
  end

  always_comb begin
    cur  = s1_first_r ? {2'b00, s1_data_r.read_pos} : cursor_r;
    hit0 = s1_first_r ? 1'b0 : hit_seen_r;
    pad0 = s1_first_r ? 1'b0 : pad_seen_r;
    dropped_nxt = s1_first_r
      ? (s1_data_r.read_flags[FLAG_SECONDARY] ||
         (req_pair_r && (!s1_data_r.read_flags[FLAG_PAIRED] ||
                         !s1_data_r.read_flags[FLAG_PROPER])))
      : dropped_r;
    walk = !dropped_nxt && !hit0 && !pad0;
    sum  = {1'b0, cur} + {(CURSOR_W+1-LEN_W)'(0), s1_data_r.cigar_len};
    overlap = (s1_data_r.cigar_len != '0) &&
              ({(CURSOR_W+1-POS_W)'(0), region_start_r} < sum) &&
              ({(CURSOR_W-POS_W)'(0), region_end_r} >= cur);

    cursor_nxt   = cur;
    hit_seen_nxt = hit0;
    pad_seen_nxt = pad0;
    if (walk) begin
      if (cls.padding) begin
        pad_seen_nxt = 1'b1;
      end else if (cls.aligned && overlap) begin
        hit_seen_nxt = 1'b1;
      end else if (cls.advances) begin
        cursor_nxt = sum[CURSOR_W] ? '1 : sum[CURSOR_W-1:0];
      end
    end

    hit_out        = hit_seen_nxt && !dropped_nxt;
    hits_total_nxt = hits_total_r;
    if (s1_last_r && hit_out && (hits_total_r != '1)) begin
      hits_total_nxt = hits_total_r + COUNT_W'(1);
    end

    out_data_nxt               = '0;
    out_data_nxt.read_hit      = hit_out;
    out_data_nxt.read_filtered = dropped_nxt;
    out_data_nxt.padding_error = pad_seen_nxt && !dropped_nxt;
    out_data_nxt.hit_count     = hits_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= '0;
      region_end_r   <= '0;
      req_pair_r     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REGION_START: region_start_r <= cfg_data;
        CFG_REGION_END:   region_end_r   <= cfg_data;
        CFG_PROPER_PAIR:  req_pair_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r  <= in_data_t'(in_tdata);
      s1_first_r <= in_tuser;
      s1_last_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r     <= '0;
      hit_seen_r   <= 1'b0;
      dropped_r    <= 1'b0;
      pad_seen_r   <= 1'b0;
      hits_total_r <= '0;
    end else if (s1_adv) begin
      cursor_r     <= cursor_nxt;
      hit_seen_r   <= hit_seen_nxt;
      dropped_r    <= dropped_nxt;
      pad_seen_r   <= pad_seen_nxt;
      hits_total_r <= hits_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_data_r <= out_data_nxt;
    end
  end

`include "assert_macros.svh"

  `RROF_ASSERT(a_count_monotonic, clk, rst_n,
    $past(rst_n) |-> hits_total_r >= $past(hits_total_r))
  `RROF_ASSERT_NEVER(a_hit_and_filtered, clk, rst_n,
    out_valid_r && out_data_r.read_filtered &&
    (out_data_r.read_hit || out_data_r.padding_error))
  `RROF_ASSERT(a_hit_counted, clk, rst_n,
    (out_valid_r && out_data_r.read_hit) |-> out_data_r.hit_count != '0)
  `RROF_ASSERT(a_ready_when_free, clk, rst_n,
    !out_valid_r |-> in_tready)

endmodule
